// ===== hdl/lmfr_pkg.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// lmfr_pkg - shared types and constants for the LED matrix frame refresh
// Buffer geometry, action codes, register indexes and the buffer command.
// -----------------------------------------------------------------------------
package lmfr_pkg;

  // Chain geometry
  localparam int MaxDevices = 4;
  localparam int ColsPerDev = 8;
  localparam int ColW       = $clog2(ColsPerDev);
  localparam int DevW       = (MaxDevices > 1) ? $clog2(MaxDevices) : 1;
  localparam int CntW       = $clog2(MaxDevices + 1);
  localparam int AddrW      = DevW + ColW;
  localparam int Depth      = MaxDevices * ColsPerDev;

  // Field widths
  localparam int ActW    = 2;
  localparam int ColIdxW = 5;
  localparam int ByteW   = 8;
  localparam int RowW    = 3;
  localparam int RegAddrW = 4;
  localparam int DevCfgW = 3;
  localparam int CfgIdxW = 1;
  localparam int CfgDataW = 3;

  // Register indexes on the configuration channel
  localparam logic [CfgIdxW-1:0] CfgOrientation = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgDeviceCount = 1'd1;

  // Input actions
  typedef enum logic [ActW-1:0] {
    ActWriteCol = 2'd0,
    ActSetPixel = 2'd1,
    ActClear    = 2'd2,
    ActRefresh  = 2'd3
  } action_e;

  // Refresh sequencer states
  typedef enum logic [1:0] {
    ScanIdle,
    ScanGather,
    ScanOut
  } scan_state_e;

  // Command to the frame buffer for one cycle
  typedef struct packed {
    logic             wr_en;
    logic [AddrW-1:0] wr_addr;
    logic [ByteW-1:0] wr_data;
    logic             clr_en;
    logic [CntW-1:0]  clr_devs;
  } buf_cmd_t;

endpackage

// ===== hdl/lmfr_buf.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// lmfr_buf - column frame buffer
// One byte per column, one write port, one read port, and a clear of all the
// columns of the modules in use together. Cleared at reset.
// -----------------------------------------------------------------------------
module lmfr_buf (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  lmfr_pkg::buf_cmd_t       cmd_i,
  input  logic [lmfr_pkg::AddrW-1:0] rd_addr_i,
  output logic [lmfr_pkg::ByteW-1:0] rd_data_o
);
  import lmfr_pkg::*;

  logic [ByteW-1:0] cols_q [Depth];

  // Write, clear, reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Depth; i++) begin
        cols_q[i] <= '0;
      end
    end else if (cmd_i.clr_en) begin
      for (int i = 0; i < Depth; i++) begin
        if (CntW'(i >> ColW) < cmd_i.clr_devs) begin
          cols_q[i] <= '0;
        end
      end
    end else if (cmd_i.wr_en) begin
      cols_q[cmd_i.wr_addr] <= cmd_i.wr_data;
    end
  end

  // Single read port
  assign rd_data_o = cols_q[rd_addr_i];

endmodule

// ===== hdl/lmfr_scan.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// lmfr_scan - refresh sequencer
// Walks row addresses and modules. In the alternate orientation a shared
// bit-insert unit builds the transposed byte over eight reads, one column a
// cycle; otherwise the column byte goes out.
// -----------------------------------------------------------------------------
module lmfr_scan (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [lmfr_pkg::CntW-1:0]   devs_i,
  input  logic                        orient_alt_i,
  output logic [lmfr_pkg::AddrW-1:0]  rd_addr_o,
  input  logic [lmfr_pkg::ByteW-1:0]  rd_data_i,
  output logic                        busy_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [lmfr_pkg::RegAddrW-1:0] out_addr_o,
  output logic [lmfr_pkg::ByteW-1:0]  out_data_o,
  output logic                        out_latch_o,
  output logic                        out_last_o
);
  import lmfr_pkg::*;

  scan_state_e      state_q, state_d;
  logic [RowW-1:0]  row_q, row_d;
  logic [DevW-1:0]  dev_q, dev_d;
  logic [ColW-1:0]  col_q, col_d;
  logic [ByteW-1:0] acc_q, acc_d;
  logic [ByteW-1:0] data_q, data_d;
  logic [ByteW-1:0] ins_bit;
  logic             frame_end;

  // Shared unit: place the row bit of this column, MSB first
  assign ins_bit = ByteW'(rd_data_i[row_q]) << (ColW'(ColsPerDev - 1) - col_q);

  assign frame_end = (CntW'(dev_q) + CntW'(1)) == devs_i;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ScanIdle;
      row_q   <= '0;
      dev_q   <= '0;
      col_q   <= '0;
      acc_q   <= '0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      dev_q   <= dev_d;
      col_q   <= col_d;
      acc_q   <= acc_d;
    end
  end

  // Output byte register
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  // Next state and outputs
  always_comb begin
    state_d = state_q;
    row_d   = row_q;
    dev_d   = dev_q;
    col_d   = col_q;
    acc_d   = acc_q;
    data_d  = data_q;
    case (state_q)
      ScanIdle: begin
        if (start_i) begin
          row_d   = '0;
          dev_d   = '0;
          col_d   = '0;
          acc_d   = '0;
          state_d = ScanGather;
        end
      end
      ScanGather: begin
        if (orient_alt_i) begin
          if (col_q == ColW'(ColsPerDev - 1)) begin
            data_d  = acc_q | ins_bit;
            acc_d   = '0;
            col_d   = '0;
            state_d = ScanOut;
          end else begin
            acc_d = acc_q | ins_bit;
            col_d = col_q + ColW'(1);
          end
        end else begin
          data_d  = rd_data_i;
          state_d = ScanOut;
        end
      end
      ScanOut: begin
        if (out_ready_i) begin
          if (frame_end) begin
            dev_d = '0;
            if (row_q == RowW'(ColsPerDev - 1)) begin
              state_d = ScanIdle;
            end else begin
              row_d   = row_q + RowW'(1);
              state_d = ScanGather;
            end
          end else begin
            dev_d   = dev_q + DevW'(1);
            state_d = ScanGather;
          end
        end
      end
      default: state_d = ScanIdle;
    endcase
  end

  assign rd_addr_o   = {dev_q, orient_alt_i ? col_q : ColW'(row_q)};
  assign busy_o      = (state_q != ScanIdle);
  assign out_valid_o = (state_q == ScanOut);
  assign out_addr_o  = RegAddrW'(row_q) + RegAddrW'(1);
  assign out_data_o  = data_q;
  assign out_latch_o = frame_end;
  assign out_last_o  = frame_end && (row_q == RowW'(ColsPerDev - 1));

endmodule

// ===== hdl/led_matrix_frame_refresh.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// led_matrix_frame_refresh - column frame buffer and refresh for 8x8 drivers
// Input items: s_axis tdata = action, column index, column value, pixel row.
// Write column, set pixel and clear act on the buffer as they are accepted; the
// next item can follow straight away. A refresh emits one item per (row address, module):
// address 1..8 outer, modules in chain order inner; tuser marks the pair
// that ends a chip-select frame, tlast the final pair of the run.
// In the transposed orientation the shared bit-insert unit reads the module's
// eight columns one per cycle through the single buffer read port before each
// pair goes out; in column orientation one read gives the pair's byte.
// s_axis_tready stays low from the refresh item until its last pair has
// been taken; a stalled receiver holds the sequencer with the pair steady.
// Configuration: index 0 orientation, index 1 device count (above four acts
// as four, zero means no module: writes ignored, refresh gives nothing).
// cfg_ready_o is always high; write only while the block is idle.
// Reset clears the buffer, sets column orientation and four modules.
// -----------------------------------------------------------------------------
module led_matrix_frame_refresh (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // action[1:0], column_index[6:2],
                                     // column_value[14:7], pixel_row[17:15]
  // Result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // reg_address[3:0], reg_data[11:4]
  output logic        m_axis_tuser,  // latch[0]
  output logic        m_axis_tlast,  // last
  // Configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [lmfr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [lmfr_pkg::CfgDataW-1:0] cfg_data_i
);
  import lmfr_pkg::*;

  logic               orient_q;
  logic [DevCfgW-1:0] dev_cfg_q;
  logic [CntW-1:0]    devs;

  logic [ActW-1:0]    in_action;
  logic [ColIdxW-1:0] in_col;
  logic [ByteW-1:0]   in_value;
  logic [RowW-1:0]    in_row;
  logic               in_acc;
  logic               in_range;

  logic               scan_busy;
  logic               scan_start;
  logic [AddrW-1:0]   scan_addr;
  logic [AddrW-1:0]   rd_addr;
  logic [ByteW-1:0]   rd_data;
  logic [RegAddrW-1:0] out_addr;
  logic [ByteW-1:0]   out_data;
  buf_cmd_t           cmd;

  // Configuration registers
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      orient_q  <= 1'b0;
      dev_cfg_q <= DevCfgW'(4);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgOrientation: orient_q  <= cfg_data_i[0];
        CfgDeviceCount: dev_cfg_q <= DevCfgW'(cfg_data_i);
        default: ;
      endcase
    end
  end

  // Modules in use, saturated at the chain size
  assign devs = (dev_cfg_q > DevCfgW'(MaxDevices)) ? CntW'(MaxDevices) : CntW'(dev_cfg_q);

  // Input unpacking
  assign in_action = s_axis_tdata[1:0];
  assign in_col    = s_axis_tdata[6:2];
  assign in_value  = s_axis_tdata[14:7];
  assign in_row    = s_axis_tdata[17:15];

  assign s_axis_tready = ~scan_busy;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign in_range      = CntW'(in_col >> ColW) < devs;
  assign scan_start    = in_acc && (in_action == ActRefresh) && (devs != '0);

  // Buffer read port: scan address while refreshing, else the item's column
  assign rd_addr = scan_busy ? scan_addr : AddrW'(in_col);

  // Buffer command from the accepted item
  always_comb begin
    cmd          = '0;
    cmd.wr_addr  = AddrW'(in_col);
    cmd.clr_devs = devs;
    cmd.wr_data  = in_value;
    if (in_acc) begin
      case (in_action)
        ActWriteCol: cmd.wr_en = in_range;
        ActSetPixel: begin
          cmd.wr_en   = in_range;
          cmd.wr_data = rd_data | (ByteW'(1) << in_row);
        end
        ActClear:    cmd.clr_en = 1'b1;
        default: ;
      endcase
    end
  end

  lmfr_buf u_buf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  lmfr_scan u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (scan_start),
    .devs_i       (devs),
    .orient_alt_i (orient_q),
    .rd_addr_o    (scan_addr),
    .rd_data_i    (rd_data),
    .busy_o       (scan_busy),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_addr_o   (out_addr),
    .out_data_o   (out_data),
    .out_latch_o  (m_axis_tuser),
    .out_last_o   (m_axis_tlast)
  );

  // Output packing
  assign m_axis_tdata = {4'b0000, out_data, out_addr};

endmodule
